// ===== hdl/rhpm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers for the rolling hash pattern matcher.
// No dependencies; imported by every other file of the block except rhpm_ram.
package rhpm_pkg;

   localparam int MAX_PATTERN  = 64;
   localparam int MAX_TEXT     = 1048576;
   localparam int HASH_W       = 64;
   localparam int LEN_W        = 7;
   localparam int SLOT_W       = $clog2(MAX_PATTERN);
   localparam int POS_W        = 21;
   localparam int CHAR_W       = 8;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 64;
   localparam int OFIFO_DEPTH  = 8;
   localparam int OFIFO_PTR_W  = $clog2(OFIFO_DEPTH);
   localparam int OFIFO_OCC_W  = $clog2(OFIFO_DEPTH + 1);
   localparam int ENTRY_W      = 2 * HASH_W;

   localparam logic [HASH_W-1:0] HASH_BASE    = HASH_W'(123);
   localparam logic [CHAR_W-1:0] CHAR_BIAS    = CHAR_W'(97);
   localparam logic [POS_W-1:0]  MAX_TEXT_POS = POS_W'(MAX_TEXT);
   localparam logic [LEN_W-1:0]  MAX_LEN      = LEN_W'(MAX_PATTERN);

   typedef enum logic [0:0] {
      REG_PATTERN_LENGTH = 1'b0,
      REG_PATTERN_HASH   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len_eff;
      logic [HASH_W-1:0] hash_x123;
   } cfg_type;

   typedef struct packed {
      logic             match;
      logic [POS_W-1:0] start_position;
      logic [POS_W-1:0] match_count;
      logic             text_done;
   } result_type;

   // multiply by the hash base: 123 = 128 - 4 - 1
   function automatic logic [HASH_W-1:0] times_base(input logic [HASH_W-1:0] v);
      return (v << 7) - (v << 2) - v;
   endfunction

endpackage

// ===== hdl/rhpm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rhpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rhpm_csr.sv =====
`timescale 1ns / 1ps
// APB-style register file: pattern length and pattern hash.
// Depends on rhpm_pkg; feeds the effective length and scaled hash to the core.
module rhpm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rhpm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rhpm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rhpm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output rhpm_pkg::cfg_type                  cfg
);
   import rhpm_pkg::*;

   logic [LEN_W-1:0]  len_ff;
   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_x123_ff;
   logic              wr_en;
   reg_index_type     reg_index;
   logic [LEN_W-1:0]  len_eff;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_W'(1);
         hash_ff      <= '0;
         hash_x123_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_PATTERN_LENGTH: len_ff <= pwdata[LEN_W-1:0];
            REG_PATTERN_HASH: begin
               hash_ff      <= pwdata[HASH_W-1:0];
               hash_x123_ff <= times_base(pwdata[HASH_W-1:0]);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PATTERN_LENGTH: prdata = CSR_DATA_W'(len_ff);
         REG_PATTERN_HASH:   prdata = CSR_DATA_W'(hash_ff);
         default:            prdata = '0;
      endcase
   end

   // clamp length into 1..MAX_PATTERN
   always_comb begin
      priority if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = len_ff;
      end
   end

   assign cfg.len_eff   = len_eff;
   assign cfg.hash_x123 = hash_x123_ff;

endmodule

// ===== hdl/rhpm_core.sv =====
`timescale 1ns / 1ps
// Hash pipeline: prefix sums of weighted bytes held in a 64-entry RAM,
// window compare by scaled pattern hash. Depends on rhpm_pkg and rhpm_ram.
module rhpm_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [rhpm_pkg::CHAR_W-1:0]   text_char,
   input  logic                          last_char,
   input  rhpm_pkg::cfg_type             cfg,
   output logic                          res_valid,
   output rhpm_pkg::result_type          res
);
   import rhpm_pkg::*;

   typedef struct packed {
      logic [HASH_W-1:0] sum;
      logic [HASH_W-1:0] weight;
   } entry_type;

   // front: per-text counters and running weight
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [POS_W-1:0]  seen_ff, seen_in;
   logic [HASH_W-1:0] weight_ff, weight_in;
   logic [LEN_W-1:0]  n_len;
   logic [POS_W-1:0]  seen_next;
   logic              char_neg;
   logic [CHAR_W-1:0] char_mag;
   logic [SLOT_W-1:0] rd_slot;

   // stage 1
   logic              s1_valid_ff;
   logic              s1_neg_ff;
   logic [CHAR_W-1:0] s1_mag_ff;
   logic [HASH_W-1:0] s1_weight_ff;
   logic              s1_last_ff;
   logic              s1_have_ff;
   logic              s1_base_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [SLOT_W-1:0] s1_rslot_ff;
   logic [POS_W-1:0]  s1_start_ff;
   logic [HASH_W-1:0] mag_prod;
   logic [HASH_W-1:0] term;
   entry_type         old_entry;
   logic [ENTRY_W-1:0] ram_rd_data;

   // stage 2
   logic              s2_valid_ff;
   logic [HASH_W-1:0] s2_term_ff;
   logic [HASH_W-1:0] s2_weight_ff;
   logic [HASH_W-1:0] s2_old_sum_ff;
   logic [HASH_W-1:0] s2_old_weight_ff;
   logic              s2_last_ff;
   logic              s2_have_ff;
   logic [SLOT_W-1:0] s2_slot_ff;
   logic [POS_W-1:0]  s2_start_ff;
   logic [HASH_W-1:0] sum_acc_ff, sum_acc_in;
   logic [HASH_W-1:0] new_sum;
   entry_type         new_entry;
   logic [HASH_W-1:0] prod_ll;
   logic [HASH_W-1:0] prod_lh;
   logic [HASH_W-1:0] prod_hl;

   // last write, for same-edge read forwarding
   logic              wr_valid_ff;
   logic [SLOT_W-1:0] wr_slot_ff;
   entry_type         wr_data_ff;

   // stage 3
   logic                s3_valid_ff;
   logic [HASH_W-1:0]   s3_diff_ff;
   logic [HASH_W-1:0]   s3_pp_ll_ff;
   logic [HASH_W/2-1:0] s3_pp_lh_ff;
   logic [HASH_W/2-1:0] s3_pp_hl_ff;
   logic                s3_last_ff;
   logic                s3_have_ff;
   logic [POS_W-1:0]    s3_start_ff;
   logic [POS_W-1:0]    count_ff, count_in;
   logic [HASH_W-1:0]   scaled_pattern;
   logic                hit;
   logic [POS_W-1:0]    count_next;

   // ---------------- front ----------------
   assign n_len     = fill_ff + LEN_W'(1);
   assign seen_next = (seen_ff == MAX_TEXT_POS) ? seen_ff : seen_ff + POS_W'(1);
   assign char_neg  = text_char < CHAR_BIAS;
   assign char_mag  = char_neg ? (CHAR_BIAS - text_char) : (text_char - CHAR_BIAS);
   assign rd_slot   = slot_ff - cfg.len_eff[SLOT_W-1:0];

   always_comb begin
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      seen_in   = seen_ff;
      weight_in = weight_ff;
      if (accept) begin
         slot_in = slot_ff + SLOT_W'(1);
         if (last_char) begin
            fill_in   = '0;
            seen_in   = '0;
            weight_in = HASH_BASE;
         end else begin
            fill_in   = (n_len > MAX_LEN) ? MAX_LEN : n_len;
            seen_in   = seen_next;
            weight_in = times_base(weight_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         fill_ff     <= '0;
         seen_ff     <= '0;
         weight_ff   <= HASH_BASE;
         s1_valid_ff <= 1'b0;
      end else begin
         slot_ff     <= slot_in;
         fill_ff     <= fill_in;
         seen_ff     <= seen_in;
         weight_ff   <= weight_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_neg_ff    <= char_neg;
      s1_mag_ff    <= char_mag;
      s1_weight_ff <= weight_ff;
      s1_last_ff   <= last_char;
      s1_have_ff   <= n_len >= cfg.len_eff;
      s1_base_ff   <= n_len == cfg.len_eff;
      s1_slot_ff   <= slot_ff;
      s1_rslot_ff  <= rd_slot;
      s1_start_ff  <= seen_next - POS_W'(cfg.len_eff) + POS_W'(1);
   end

   // ---------------- prefix store ----------------
   rhpm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PATTERN)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_slot_ff),
      .wr_data (new_entry),
      .rd_addr (rd_slot),
      .rd_data (ram_rd_data)
   );

   // ---------------- stage 1 ----------------
   assign mag_prod = s1_weight_ff * HASH_W'(s1_mag_ff);
   assign term     = s1_neg_ff ? (HASH_W'(0) - mag_prod) : mag_prod;

   always_comb begin
      priority if (s1_base_ff) begin
         old_entry.sum    = '0;
         old_entry.weight = HASH_W'(1);
      end else if (s2_valid_ff && (s2_slot_ff == s1_rslot_ff)) begin
         old_entry = new_entry;
      end else if (wr_valid_ff && (wr_slot_ff == s1_rslot_ff)) begin
         old_entry = wr_data_ff;
      end else begin
         old_entry = entry_type'(ram_rd_data);
      end
   end

   always_ff @(posedge clock) begin
      s2_term_ff       <= term;
      s2_weight_ff     <= s1_weight_ff;
      s2_old_sum_ff    <= old_entry.sum;
      s2_old_weight_ff <= old_entry.weight;
      s2_last_ff       <= s1_last_ff;
      s2_have_ff       <= s1_have_ff;
      s2_slot_ff       <= s1_slot_ff;
      s2_start_ff      <= s1_start_ff;
      wr_slot_ff       <= s2_slot_ff;
      wr_data_ff       <= new_entry;
   end

   // ---------------- stage 2 ----------------
   assign new_sum          = sum_acc_ff + s2_term_ff;
   assign new_entry.sum    = new_sum;
   assign new_entry.weight = s2_weight_ff;

   always_comb begin
      sum_acc_in = sum_acc_ff;
      if (s2_valid_ff) begin
         sum_acc_in = s2_last_ff ? '0 : new_sum;
      end
   end

   assign prod_ll = cfg.hash_x123[HASH_W/2-1:0] * s2_old_weight_ff[HASH_W/2-1:0];
   assign prod_lh = cfg.hash_x123[HASH_W/2-1:0] * s2_old_weight_ff[HASH_W-1:HASH_W/2];
   assign prod_hl = cfg.hash_x123[HASH_W-1:HASH_W/2] * s2_old_weight_ff[HASH_W/2-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
         sum_acc_ff  <= '0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         wr_valid_ff <= s2_valid_ff;
         sum_acc_ff  <= sum_acc_in;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_diff_ff  <= new_sum - s2_old_sum_ff;
      s3_pp_ll_ff <= prod_ll;
      s3_pp_lh_ff <= prod_lh[HASH_W/2-1:0];
      s3_pp_hl_ff <= prod_hl[HASH_W/2-1:0];
      s3_last_ff  <= s2_last_ff;
      s3_have_ff  <= s2_have_ff;
      s3_start_ff <= s2_start_ff;
   end

   // ---------------- stage 3 ----------------
   assign scaled_pattern = s3_pp_ll_ff + {s3_pp_lh_ff + s3_pp_hl_ff, {(HASH_W/2){1'b0}}};
   assign hit            = s3_have_ff && (scaled_pattern == s3_diff_ff);

   always_comb begin
      count_next = count_ff;
      if (hit && (count_ff != MAX_TEXT_POS)) begin
         count_next = count_ff + POS_W'(1);
      end
      count_in = count_ff;
      if (s3_valid_ff) begin
         count_in = s3_last_ff ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign res_valid          = s3_valid_ff;
   assign res.match          = hit;
   assign res.start_position = hit ? s3_start_ff : '0;
   assign res.match_count    = count_next;
   assign res.text_done      = s3_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_LEN)
      else $error("window fill beyond pattern store depth");

   a_pipe_flow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> s2_valid_ff && s3_valid_ff == $past(s2_valid_ff))
      else $error("word lost inside hash pipeline");

   a_hit_start: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && hit) |-> (s3_start_ff != '0))
      else $error("match reported with zero start position");

endmodule

// ===== hdl/rhpm_ofifo.sv =====
`timescale 1ns / 1ps
// Result queue with credit count: stalls the input once every slot is spoken for.
// Depends on rhpm_pkg.
module rhpm_ofifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  reserve,
   input  logic                  push,
   input  rhpm_pkg::result_type  push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  out_valid,
   output rhpm_pkg::result_type  out_data
);
   import rhpm_pkg::*;

   result_type               store_ff [OFIFO_DEPTH];
   logic [OFIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OFIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OFIFO_OCC_W-1:0]   count_ff, count_in;
   logic [OFIFO_OCC_W-1:0]   occ_ff, occ_in;

   assign wr_ptr_in = push ? wr_ptr_ff + OFIFO_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + OFIFO_PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + OFIFO_OCC_W'(push) - OFIFO_OCC_W'(pop);
   assign occ_in    = occ_ff + OFIFO_OCC_W'(reserve) - OFIFO_OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = occ_ff == OFIFO_OCC_W'(OFIFO_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = store_ff[rd_ptr_ff];

   a_credit_cover: assert property (@(posedge clock) disable iff (reset)
      count_ff <= occ_ff)
      else $error("queued words exceed reserved credits");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != OFIFO_OCC_W'(OFIFO_DEPTH)) || pop)
      else $error("result queue overflow");

endmodule

// ===== hdl/rolling_hash_pattern_match.sv =====
`timescale 1ns / 1ps
// Rolling hash pattern matcher, top level.
// Depends on rhpm_pkg, rhpm_csr, rhpm_core, rhpm_ofifo (and rhpm_ram through the core).
//
// Usage:
//   Input words (req_) carry one text byte and a last-byte flag; each is taken
//   at an edge with req_valid high and req_stall low. Every input word yields
//   exactly one result word (rsp_): match flag, 1-based start of the matching
//   window, running match count and a text-done flag echoing the last byte.
//   An accepted word passes the core hash pipeline and the result queue to rsp_valid;
//   throughput is one word per cycle while req_stall is low, set by one prefix sum add
//   and one RAM access per word. Results queue in an 8-deep buffer; req_stall rises
//   only once 8 words are accepted but not yet taken, so a stalled receiver backs up
//   the input after that many words and nothing is lost.
//   Configuration (pattern length at 0x0, pattern hash at 0x8) is written over
//   the APB port while no word is in flight; the hash is the pattern's sum of
//   (byte - 97) * 123^k mod 2^64, k = 0 for the first pattern byte.
//   Reset clears the counters, the queue and the registers (length 1, hash 0);
//   the prefix RAM needs no clearing, entries are used only after being written.
module rolling_hash_pattern_match (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rhpm_pkg::CHAR_W-1:0]        req_text_char,
   input  logic                               req_last_char,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_match,
   output logic [rhpm_pkg::POS_W-1:0]         rsp_start_position,
   output logic [rhpm_pkg::POS_W-1:0]         rsp_match_count,
   output logic                               rsp_text_done,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rhpm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rhpm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rhpm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import rhpm_pkg::*;

   cfg_type    cfg;
   result_type core_res;
   result_type head;
   logic       core_valid;
   logic       accept;
   logic       pop;
   logic       queue_full;

   assign accept    = req_valid & ~queue_full;
   assign req_stall = queue_full;
   assign pop       = rsp_valid & ~rsp_stall;

   rhpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rhpm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_char (req_text_char),
      .last_char (req_last_char),
      .cfg       (cfg),
      .res_valid (core_valid),
      .res       (core_res)
   );

   rhpm_ofifo u_ofifo (
      .clock     (clock),
      .reset     (reset),
      .reserve   (accept),
      .push      (core_valid),
      .push_data (core_res),
      .pop       (pop),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_data  (head)
   );

   assign rsp_match          = head.match;
   assign rsp_start_position = head.start_position;
   assign rsp_match_count    = head.match_count;
   assign rsp_text_done      = head.text_done;

endmodule
